@@ rtl/rwsg_pkg.sv @@
// ricker wavelet sample generator: shared types and fixed-point constants
// no dependencies; used by ricker_wavelet_sample_generator_top
`timescale 1ns / 1ps
`default_nettype none

package rwsg_pkg;

    // register index taken from paddr[2]
    localparam logic REG_WIDTH_A = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    localparam logic [23:0] WIDTH_A_RST = 24'd1024;
    localparam logic [16:0] LENGTH_RST  = 17'd64;
    localparam logic [23:0] WIDTH_A_MIN = 24'd256;

    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [50:0] NORM_K    = 51'd1691384361080388;
    localparam logic [29:0] ONE_Q24   = 30'h100_0000;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [61:0] ROUND_37  = 62'h10_0000_0000;
    localparam logic [24:0] SAT_POS   = 25'd131071;
    localparam logic [24:0] SAT_NEG   = 25'd131072;

    localparam int unsigned DIV_BITS  = 27;
    localparam int unsigned EXP_TERMS = 12;

    // per-item side flags carried down the pipeline
    typedef struct packed {
        logic last;
        logic oor;
        logic zero;
    } t_flags;

    // normalization unit sequencer
    typedef enum logic [2:0] {
        NS_LOAD,
        NS_SQRT,
        NS_PREP,
        NS_DIV,
        NS_IDLE
    } t_nstate;

endpackage

`default_nettype wire

@@ rtl/ricker_wavelet_sample_generator_top.sv @@
// ricker wavelet sample generator: apb registers, norm unit, sample pipeline
// depends on rwsg_pkg
//
// usage: each request on the s-side stream carries a sample index n; one
// result per request leaves on the m-side stream with the Q1.17 wavelet
// value in tdata, tlast set on the last index of the window (n == M-1)
// and tuser set when n is outside the window (value then zero).
// width a and window length M are written over the apb port while idle.
// throughput: one request per cycle while the norm unit is idle and the
// receiver does not stall; the pipeline holds the 27-stage divider for
// |t|/a and the 12-term exp series at three stages per term.
// a write to width_a (and reset) starts the normalization unit: bitwise
// square root of 3a then a bit-serial divide, while s-side tready stays
// low; length writes take effect at once.
// reset clears all valid bits and the registers to a = 4.0, M = 64.
// when the receiver stalls the whole pipeline holds in place and tready
// drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module ricker_wavelet_sample_generator_top #(
    parameter int MAX_LEN = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // s side request
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [15:0] sample_index
    // m side result
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // [17:0] sample_value, [23:18] zero
    output logic        o_m_tlast,   // last_sample
    output logic        o_m_tuser,   // [0] out_of_range
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned DivN = rwsg_pkg::DIV_BITS;
    localparam int unsigned ExpN = rwsg_pkg::EXP_TERMS;
    localparam logic [20:0] MaxLenW = 21'(MAX_LEN);

    // ---------------- config registers ----------------
    logic [23:0] r_width_a;
    logic [16:0] r_length;
    logic        cfg_wr;
    logic [23:0] a_eff;
    logic [16:0] m_len;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_a <= rwsg_pkg::WIDTH_A_RST;
            r_length  <= rwsg_pkg::LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                rwsg_pkg::REG_WIDTH_A: r_width_a <= pwdata[23:0];
                rwsg_pkg::REG_LENGTH:  r_length  <= pwdata[16:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rwsg_pkg::REG_WIDTH_A: prdata = {8'd0, r_width_a};
            rwsg_pkg::REG_LENGTH:  prdata = {15'd0, r_length};
        endcase
    end

    assign a_eff = (r_width_a < rwsg_pkg::WIDTH_A_MIN) ? rwsg_pkg::WIDTH_A_MIN : r_width_a;
    assign m_len = ({4'd0, r_length} > MaxLenW) ? MaxLenW[16:0] : r_length;

    // ---------------- normalization unit ----------------
    // norm = round(K / floor(sqrt(3a * 2^32))), recomputed after each width write
    rwsg_pkg::t_nstate r_nstate, n_nstate;
    logic [57:0] r_sq_v,    n_sq_v;
    logic [29:0] r_sq_rem,  n_sq_rem;
    logic [28:0] r_sq_root, n_sq_root;
    logic [50:0] r_nd_num,  n_nd_num;
    logic [28:0] r_nd_rem,  n_nd_rem;
    logic [5:0]  r_cnt,     n_cnt;
    logic [31:0] sq_sh;
    logic [31:0] sq_trial;
    logic [29:0] nd_sh;
    logic [29:0] norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nstate <= rwsg_pkg::NS_LOAD;
        end else begin
            r_nstate <= n_nstate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_v    <= n_sq_v;
        r_sq_rem  <= n_sq_rem;
        r_sq_root <= n_sq_root;
        r_nd_num  <= n_nd_num;
        r_nd_rem  <= n_nd_rem;
        r_cnt     <= n_cnt;
    end

    assign sq_sh    = {r_sq_rem, r_sq_v[57:56]};
    assign sq_trial = {1'b0, r_sq_root, 2'b01};
    assign nd_sh    = {r_nd_rem, r_nd_num[50]};

    always_comb begin
        n_nstate  = r_nstate;
        n_sq_v    = r_sq_v;
        n_sq_rem  = r_sq_rem;
        n_sq_root = r_sq_root;
        n_nd_num  = r_nd_num;
        n_nd_rem  = r_nd_rem;
        n_cnt     = r_cnt;
        unique case (r_nstate)
            rwsg_pkg::NS_LOAD: begin
                n_sq_v    = {26'({2'd0, a_eff}) + 26'({1'b0, a_eff, 1'b0}), 32'd0};
                n_sq_rem  = '0;
                n_sq_root = '0;
                n_cnt     = 6'd28;
                n_nstate  = rwsg_pkg::NS_SQRT;
            end
            rwsg_pkg::NS_SQRT: begin
                // one result bit per cycle, two radicand bits in
                if (sq_sh >= sq_trial) begin
                    n_sq_rem  = 30'(sq_sh - sq_trial);
                    n_sq_root = {r_sq_root[27:0], 1'b1};
                end else begin
                    n_sq_rem  = sq_sh[29:0];
                    n_sq_root = {r_sq_root[27:0], 1'b0};
                end
                n_sq_v = {r_sq_v[55:0], 2'b00};
                n_cnt  = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_nstate = rwsg_pkg::NS_PREP;
                end
            end
            rwsg_pkg::NS_PREP: begin
                n_nd_num = rwsg_pkg::NORM_K + 51'(r_sq_root[28:1]);
                n_nd_rem = '0;
                n_cnt    = 6'd50;
                n_nstate = rwsg_pkg::NS_DIV;
            end
            rwsg_pkg::NS_DIV: begin
                // quotient bits shift in at the bottom of the numerator
                if (nd_sh >= {1'b0, r_sq_root}) begin
                    n_nd_rem = 29'(nd_sh - {1'b0, r_sq_root});
                    n_nd_num = {r_nd_num[49:0], 1'b1};
                end else begin
                    n_nd_rem = nd_sh[28:0];
                    n_nd_num = {r_nd_num[49:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_nstate = rwsg_pkg::NS_IDLE;
                end
            end
            rwsg_pkg::NS_IDLE: begin
                n_nstate = rwsg_pkg::NS_IDLE;
            end
            default: begin
                n_nstate = rwsg_pkg::NS_LOAD;
            end
        endcase
        if (cfg_wr && (paddr[2] == rwsg_pkg::REG_WIDTH_A)) begin
            n_nstate = rwsg_pkg::NS_LOAD;
        end
    end

    assign norm = r_nd_num[29:0];

    // ---------------- sample pipeline ----------------
    logic adv;
    logic accept;
    logic r_o_vld;

    assign adv        = !r_o_vld || i_m_tready;
    assign o_s_tready = adv && (r_nstate == rwsg_pkg::NS_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // input register
    logic        r_v0;
    logic [15:0] r_n0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n0 <= i_s_tdata;
        end
    end

    // window check and |t| in half steps
    logic           in_range;
    logic [16:0]    mm1;
    logic [17:0]    t2;
    logic [16:0]    at2;
    rwsg_pkg::t_flags fl0;

    assign in_range = {1'b0, r_n0} < m_len;
    assign mm1      = m_len - 17'd1;
    assign t2       = {1'b0, r_n0, 1'b0} - {1'b0, mm1};
    assign at2      = t2[17] ? 17'(-t2) : t2[16:0];
    assign fl0.oor  = !in_range;
    assign fl0.last = in_range && ({1'b0, r_n0} == mm1);
    // |t/a| >= 8 gives zero
    assign fl0.zero = !in_range || ({3'd0, at2, 4'd0} >= a_eff);

    // divider u = floor(|t2| * 2^31 / a), one quotient bit per stage
    logic             r_dv_vld [0:DivN];
    rwsg_pkg::t_flags r_dv_fl  [0:DivN];
    logic [23:0]      r_dv_rem [0:DivN];
    logic [26:0]      r_dv_q   [0:DivN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (adv) begin
            r_dv_vld[0] <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_fl[0]  <= fl0;
            r_dv_rem[0] <= {3'd0, at2, 4'd0};
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar d = 0; d < DivN; d++) begin : g_div
        logic [24:0] n_sh;
        logic        n_ge;

        assign n_sh = {r_dv_rem[d], 1'b0};
        assign n_ge = n_sh >= {1'b0, a_eff};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[d+1] <= 1'b0;
            end else if (adv) begin
                r_dv_vld[d+1] <= r_dv_vld[d];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_fl[d+1]  <= r_dv_fl[d];
                r_dv_rem[d+1] <= n_ge ? 24'(n_sh - {1'b0, a_eff}) : n_sh[23:0];
                r_dv_q[d+1]   <= {r_dv_q[d][25:0], n_ge};
            end
        end
    end

    // s = u^2, then y = (s/2) * log2(e), then z = frac(y) * ln2
    logic             r_s_vld, r_y_vld;
    rwsg_pkg::t_flags r_s_fl, r_y_fl;
    logic [29:0]      r_s_s, r_y_s;
    logic [5:0]       r_y_k;
    logic [23:0]      r_y_f;
    logic [53:0]      n_s_prod, n_y_prod, n_z_prod;

    assign n_s_prod = 54'(r_dv_q[DivN]) * 54'(r_dv_q[DivN]);
    assign n_y_prod = 54'(r_s_s[29:1]) * 54'(rwsg_pkg::LOG2E_Q24);
    assign n_z_prod = 54'(r_y_f) * 54'(rwsg_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_y_vld <= 1'b0;
        end else if (adv) begin
            r_s_vld <= r_dv_vld[DivN];
            r_y_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s_fl <= r_dv_fl[DivN];
            r_s_s  <= n_s_prod[53:24];
            r_y_fl <= r_s_fl;
            r_y_s  <= r_s_s;
            r_y_k  <= n_y_prod[53:48];
            r_y_f  <= n_y_prod[47:24];
        end
    end

    // exp(-z) series, Horner form, three stages per term
    logic             r_h_vld [0:ExpN];
    rwsg_pkg::t_flags r_h_fl  [0:ExpN];
    logic [29:0]      r_h_z   [0:ExpN];
    logic [30:0]      r_h_p   [0:ExpN];
    logic [29:0]      r_h_s   [0:ExpN];
    logic [5:0]       r_h_k   [0:ExpN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld[0] <= 1'b0;
        end else if (adv) begin
            r_h_vld[0] <= r_y_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h_fl[0] <= r_y_fl;
            r_h_z[0]  <= n_z_prod[53:24];
            r_h_p[0]  <= rwsg_pkg::ONE_Q30;
            r_h_s[0]  <= r_y_s;
            r_h_k[0]  <= r_y_k;
        end
    end

    for (genvar i = 0; i < ExpN; i++) begin : g_exp
        localparam int unsigned   Jv = ExpN - i;
        localparam logic [3:0]    Jc = 4'(Jv);
        // floor((2^32-1)/j): quotient estimate is low by at most one
        localparam logic [31:0]   Mj = 32'(64'hFFFF_FFFF / Jv);

        logic             r_ha_vld, r_hb_vld;
        rwsg_pkg::t_flags r_ha_fl, r_hb_fl;
        logic [29:0]      r_ha_w, r_hb_w, r_hb_q0;
        logic [29:0]      r_ha_z, r_hb_z, r_ha_s, r_hb_s;
        logic [5:0]       r_ha_k, r_hb_k;
        logic [60:0]      n_prod_a;
        logic [61:0]      n_prod_b;
        logic [33:0]      n_qj;
        logic [33:0]      n_r;
        logic [29:0]      n_q;

        assign n_prod_a = 61'(r_h_z[i]) * 61'(r_h_p[i]);
        assign n_prod_b = 62'(r_ha_w) * 62'(Mj);
        assign n_qj     = 34'(r_hb_q0) * 34'(Jc);
        assign n_r      = 34'(r_hb_w) - n_qj;
        assign n_q      = (n_r >= 34'(Jc)) ? r_hb_q0 + 30'd1 : r_hb_q0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ha_vld     <= 1'b0;
                r_hb_vld     <= 1'b0;
                r_h_vld[i+1] <= 1'b0;
            end else if (adv) begin
                r_ha_vld     <= r_h_vld[i];
                r_hb_vld     <= r_ha_vld;
                r_h_vld[i+1] <= r_hb_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ha_fl     <= r_h_fl[i];
                r_ha_w      <= n_prod_a[59:30];
                r_ha_z      <= r_h_z[i];
                r_ha_s      <= r_h_s[i];
                r_ha_k      <= r_h_k[i];
                r_hb_fl     <= r_ha_fl;
                r_hb_w      <= r_ha_w;
                r_hb_q0     <= n_prod_b[61:32];
                r_hb_z      <= r_ha_z;
                r_hb_s      <= r_ha_s;
                r_hb_k      <= r_ha_k;
                r_h_fl[i+1] <= r_hb_fl;
                r_h_z[i+1]  <= r_hb_z;
                r_h_p[i+1]  <= rwsg_pkg::ONE_Q30 - {1'b0, n_q};
                r_h_s[i+1]  <= r_hb_s;
                r_h_k[i+1]  <= r_hb_k;
            end
        end
    end

    // e = 2^-k * exp(-z), g = 1 - s, then m = |g|*e, then m * norm
    logic             r_e_vld, r_m_vld, r_n_vld;
    rwsg_pkg::t_flags r_e_fl, r_m_fl, r_n_fl;
    logic             r_e_neg, r_m_neg, r_n_neg;
    logic [30:0]      r_e_e;
    logic [29:0]      r_e_g;
    logic [30:0]      r_m_m;
    logic [60:0]      r_n_prod;
    logic             n_neg;
    logic [60:0]      n_m_prod;

    assign n_neg    = r_h_s[ExpN] > rwsg_pkg::ONE_Q24;
    assign n_m_prod = 61'(r_e_g) * 61'(r_e_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_n_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= r_h_vld[ExpN];
            r_m_vld <= r_e_vld;
            r_n_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_fl   <= r_h_fl[ExpN];
            r_e_neg  <= n_neg;
            r_e_e    <= r_h_p[ExpN] >> r_h_k[ExpN];
            r_e_g    <= n_neg ? r_h_s[ExpN] - rwsg_pkg::ONE_Q24
                              : rwsg_pkg::ONE_Q24 - r_h_s[ExpN];
            r_m_fl   <= r_e_fl;
            r_m_neg  <= r_e_neg;
            r_m_m    <= n_m_prod[60:30];
            r_n_fl   <= r_m_fl;
            r_n_neg  <= r_m_neg;
            r_n_prod <= 61'(r_m_m) * 61'(norm);
        end
    end

    // round, saturate, sign
    logic [61:0] n_sum;
    logic [24:0] n_mag;
    logic [17:0] n_val;
    logic [17:0] r_o_val;
    logic        r_o_last;
    logic        r_o_oor;

    assign n_sum = 62'(r_n_prod) + rwsg_pkg::ROUND_37;
    assign n_mag = n_sum[61:37];

    always_comb begin
        priority if (r_n_fl.zero) begin
            n_val = '0;
        end else if (r_n_neg) begin
            n_val = (n_mag > rwsg_pkg::SAT_NEG) ? 18'(-rwsg_pkg::SAT_NEG) : 18'(-n_mag);
        end else begin
            n_val = (n_mag > rwsg_pkg::SAT_POS) ? rwsg_pkg::SAT_POS[17:0] : n_mag[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= r_n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_val  <= n_val;
            r_o_last <= r_n_fl.last;
            r_o_oor  <= r_n_fl.oor;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {6'd0, r_o_val};
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_oor;

    // ---------------- checks ----------------
    a_busy_no_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nstate != rwsg_pkg::NS_IDLE) |-> !o_s_tready)
        else $error("request taken while norm unit busy");

    a_width_restarts_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (paddr[2] == rwsg_pkg::REG_WIDTH_A)) |=> (r_nstate == rwsg_pkg::NS_LOAD))
        else $error("width write did not restart norm unit");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> ((o_m_tdata == 24'd0) && !o_m_tlast))
        else $error("out-of-range result not zero");

endmodule

`default_nettype wire
